[rtl/ssd_pkg.sv]
// Shared types, command codes and the character font for the seven-segment scan display.
// No dependencies; the frame store and top level use scoped names, the bench imports it.
`default_nettype none

package ssd_pkg;

  typedef enum logic [3:0] {
    ActTick       = 4'd0,
    ActUpperChar  = 4'd1,
    ActLowerChar  = 4'd2,
    ActClearUpper = 4'd3,
    ActClearLower = 4'd4,
    ActLed        = 4'd5,
    ActRaw        = 4'd6,
    ActSetAll     = 4'd7,
    ActClearAll   = 4'd8,
    ActTurretOn   = 4'd9,
    ActTurretOff  = 4'd10
  } action_e;

  typedef struct packed {
    logic [3:0] action;
    logic [3:0] position;
    logic [7:0] value;
  } cmd_t;

  typedef struct packed {
    logic [3:0] scan_slot;
    logic [7:0] segment_byte;
    logic       turret_lit;
  } scan_t;

  localparam logic [7:0] SegAllOn = 8'hFF;
  localparam logic [7:0] SegDash  = 8'h40;  // segment G
  localparam logic [7:0] SegUnder = 8'h08;  // segment D

  localparam logic [7:0] FontDigits [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  // W and X share one pattern
  localparam logic [7:0] FontLetters [26] = '{
    8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h06, 8'h1E,
    8'h72, 8'h38, 8'h55, 8'h54, 8'h3F, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
    8'h3E, 8'h1C, 8'h49, 8'h49, 8'h6E, 8'h48
  };

  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChUnder  = 8'h5F;

  function automatic logic [7:0] glyph_of(input logic [7:0] code);
    logic [7:0] off;
    logic [7:0] seg;
    off = '0;
    seg = '0;
    if (code >= ChUpperA && code <= ChUpperZ) begin
      off = code - ChUpperA;
      seg = FontLetters[off[4:0]];
    end else if (code >= ChLowerA && code <= ChLowerZ) begin
      off = code - ChLowerA;
      seg = FontLetters[off[4:0]];
    end else if (code >= ChZero && code <= ChNine) begin
      off = code - ChZero;
      seg = FontDigits[off[3:0]];
    end else if (code == ChDash) begin
      seg = SegDash;
    end else if (code == ChUnder) begin
      seg = SegUnder;
    end
    return seg;
  endfunction

endpackage

`default_nettype wire

[rtl/ssd_if.sv]
// Valid/ready channel interfaces for the command words and the scan words.
// Depends on nothing; used by the top level of the seven-segment scan display.
`default_nettype none

interface ssd_cmd_if;
  logic       valid;
  logic       ready;
  logic [3:0] action;
  logic [3:0] position;
  logic [7:0] value;

  modport source (output valid, action, position, value, input ready);
  modport sink   (input valid, action, position, value, output ready);
endinterface

interface ssd_scan_if;
  logic       valid;
  logic       ready;
  logic [3:0] scan_slot;
  logic [7:0] segment_byte;
  logic       turret_lit;

  modport source (output valid, scan_slot, segment_byte, turret_lit, input ready);
  modport sink   (input valid, scan_slot, segment_byte, turret_lit, output ready);
endinterface

`default_nettype wire

[rtl/ssd_frame_store.sv]
// Frame store of the scan display: digit bytes, LED byte, turret flag and scan pointer.
// Executes one registered command word per enable; uses ssd_pkg.
`default_nettype none

module ssd_frame_store #(
  parameter int UPPER_DIGITS = 4,
  parameter int LOWER_DIGITS = 4,
  parameter int LED_COUNT    = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          exec_i,
  input  ssd_pkg::cmd_t cmd_i,
  output ssd_pkg::scan_t scan_o
);

  localparam int DigitTotal = UPPER_DIGITS + LOWER_DIGITS;
  localparam int SlotCount  = DigitTotal + 1;
  localparam int PtrW       = $clog2(SlotCount);
  localparam int IdxW       = $clog2(DigitTotal);

  logic [7:0]      digit_q [DigitTotal];
  logic [7:0]      digit_d [DigitTotal];
  logic [7:0]      led_q, led_d;
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic            turret_q, turret_d;

  logic [7:0]      glyph;
  logic [IdxW-1:0] lower_idx;
  logic [PtrW+3:0] slot_wide;

  always_comb begin
    digit_d   = digit_q;
    led_d     = led_q;
    ptr_d     = ptr_q;
    turret_d  = turret_q;
    glyph     = ssd_pkg::glyph_of(cmd_i.value);
    lower_idx = IdxW'(UPPER_DIGITS + int'(cmd_i.position));
    if (exec_i) begin
      unique case (ssd_pkg::action_e'(cmd_i.action))
        ssd_pkg::ActTick: begin
          ptr_d = (ptr_q == PtrW'(SlotCount - 1)) ? '0 : ptr_q + 1'b1;
        end
        ssd_pkg::ActUpperChar: begin
          if (int'(cmd_i.position) < UPPER_DIGITS) begin
            digit_d[cmd_i.position[IdxW-1:0]] = glyph;
          end
        end
        ssd_pkg::ActLowerChar: begin
          if (int'(cmd_i.position) < LOWER_DIGITS) begin
            digit_d[lower_idx] = glyph;
          end
        end
        ssd_pkg::ActClearUpper: begin
          for (int i = 0; i < UPPER_DIGITS; i++) digit_d[i] = '0;
        end
        ssd_pkg::ActClearLower: begin
          for (int i = UPPER_DIGITS; i < DigitTotal; i++) digit_d[i] = '0;
        end
        ssd_pkg::ActLed: begin
          if (int'(cmd_i.position) < LED_COUNT && int'(cmd_i.position) < 8) begin
            led_d[cmd_i.position[2:0]] = cmd_i.value[0];
          end
        end
        ssd_pkg::ActRaw: begin
          if (int'(cmd_i.position) < DigitTotal) begin
            digit_d[cmd_i.position[IdxW-1:0]] = cmd_i.value;
          end else if (int'(cmd_i.position) == DigitTotal) begin
            led_d = cmd_i.value;
          end
        end
        ssd_pkg::ActSetAll: begin
          for (int i = 0; i < DigitTotal; i++) digit_d[i] = ssd_pkg::SegAllOn;
          led_d    = ssd_pkg::SegAllOn;
          turret_d = 1'b1;
        end
        ssd_pkg::ActClearAll: begin
          for (int i = 0; i < DigitTotal; i++) digit_d[i] = '0;
          led_d    = '0;
          turret_d = 1'b0;
        end
        ssd_pkg::ActTurretOn:  turret_d = 1'b1;
        ssd_pkg::ActTurretOff: turret_d = 1'b0;
        default: ;  // unused codes leave everything as is
      endcase
    end
  end

  // Slot shown this tick; the last slot carries the LED byte
  always_comb begin
    slot_wide           = {4'b0000, ptr_q};
    scan_o.scan_slot    = slot_wide[3:0];
    scan_o.turret_lit   = turret_q;
    if (int'(ptr_q) < DigitTotal) begin
      scan_o.segment_byte = digit_q[ptr_q[IdxW-1:0]];
    end else begin
      scan_o.segment_byte = led_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q  <= '{default: 8'h00};
      led_q    <= '0;
      ptr_q    <= '0;
      turret_q <= 1'b0;
    end else begin
      digit_q  <= digit_d;
      led_q    <= led_d;
      ptr_q    <= ptr_d;
      turret_q <= turret_d;
    end
  end

endmodule

`default_nettype wire

[rtl/seven_segment_scan_display.sv]
// Top level of the multiplexed seven-segment scan display: command register,
// frame store and scan word output register. Uses ssd_pkg, ssd_if and ssd_frame_store.
`default_nettype none

// A command word enters a command register and is executed on the frame store from
// there; an executed tick loads its scan word into the scan output register, which
// holds it valid until it is taken. One command word is taken every
// cycle; only a tick that finds the output register full and unread stalls the
// command register, and with it the input. Every other command gives no scan word.
// Slots 0 to UPPER_DIGITS-1 are the upper digits, then the lower digits, then the
// LED byte; the scan wraps after the LED slot. The store is cleared at reset.
module seven_segment_scan_display #(
  parameter int UPPER_DIGITS = 4,
  parameter int LOWER_DIGITS = 4,
  parameter int LED_COUNT    = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  ssd_cmd_if.sink    cmd_i,
  ssd_scan_if.source scan_o
);

  ssd_pkg::cmd_t  cmd_q;
  logic           cmd_valid_q;
  ssd_pkg::scan_t store_scan;
  ssd_pkg::scan_t out_q;
  logic           out_valid_q;

  logic is_tick;
  logic out_free;
  logic cmd_go;

  assign is_tick  = (ssd_pkg::action_e'(cmd_q.action) == ssd_pkg::ActTick);
  assign out_free = !out_valid_q || scan_o.ready;
  assign cmd_go   = cmd_valid_q && (!is_tick || out_free);

  assign cmd_i.ready = !cmd_valid_q || cmd_go;

  // Command register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      cmd_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      cmd_q.action   <= cmd_i.action;
      cmd_q.position <= cmd_i.position;
      cmd_q.value    <= cmd_i.value;
    end
  end

  ssd_frame_store #(
    .UPPER_DIGITS (UPPER_DIGITS),
    .LOWER_DIGITS (LOWER_DIGITS),
    .LED_COUNT    (LED_COUNT)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .exec_i (cmd_go),
    .cmd_i  (cmd_q),
    .scan_o (store_scan)
  );

  // Scan word register: load on an executed tick, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_go && is_tick) begin
      out_valid_q <= 1'b1;
    end else if (scan_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_go && is_tick) begin
      out_q <= store_scan;
    end
  end

  assign scan_o.valid        = out_valid_q;
  assign scan_o.scan_slot    = out_q.scan_slot;
  assign scan_o.segment_byte = out_q.segment_byte;
  assign scan_o.turret_lit   = out_q.turret_lit;

endmodule

`default_nettype wire

[bench/seven_segment_scan_display_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for the seven-segment scan display: directed table, then random words.
// Depends on ssd_pkg, ssd_cmd_if / ssd_scan_if and the seven_segment_scan_display top level.

module seven_segment_scan_display_test;
  import ssd_pkg::*;

  localparam int UpperDigits = 4;
  localparam int LowerDigits = 4;
  localparam int LedCount    = 8;
  localparam int DigitTotal  = UpperDigits + LowerDigits;
  localparam int SlotCount   = DigitTotal + 1;
  localparam int RandomWords = 1300;

  // codes the block decodes to nothing
  localparam logic [3:0] ActSpareLow  = 4'd11;
  localparam logic [3:0] ActSpareHigh = 4'd15;

  localparam logic [7:0] DigitGlyphs [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };
  localparam logic [7:0] LetterGlyphs [26] = '{
    8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D, 8'h76, 8'h06, 8'h1E,
    8'h72, 8'h38, 8'h55, 8'h54, 8'h3F, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
    8'h3E, 8'h1C, 8'h49, 8'h49, 8'h6E, 8'h48
  };

  typedef struct {
    cmd_t  word;
    bit    typed;
    scan_t typed_scan;
  } row_t;

  logic clk_i;
  logic rst_ni;

  ssd_cmd_if  cmd_ch ();
  ssd_scan_if scan_ch ();

  seven_segment_scan_display #(
    .UPPER_DIGITS(UpperDigits),
    .LOWER_DIGITS(LowerDigits),
    .LED_COUNT   (LedCount)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_ch),
    .scan_o(scan_ch)
  );

  // shadow of the display state
  logic [7:0] digit_bytes [DigitTotal];
  logic [7:0] led_byte;
  logic [3:0] scan_ptr;
  logic       turret_flag;

  scan_t pending_scans [$];
  row_t  directed_rows [$];
  int    mismatches;
  int    burst_left;
  int    stall_mode;
  int    stall_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [7:0] glyph_for(input logic [7:0] ch);
    logic [7:0] seg;
    seg = 8'h00;
    if (ch >= ChUpperA && ch <= ChUpperZ) seg = LetterGlyphs[ch - ChUpperA];
    else if (ch >= ChLowerA && ch <= ChLowerZ) seg = LetterGlyphs[ch - ChLowerA];
    else if (ch >= ChZero && ch <= ChNine) seg = DigitGlyphs[ch - ChZero];
    else if (ch == ChDash) seg = 8'h40;
    else if (ch == ChUnder) seg = 8'h08;
    return seg;
  endfunction

  // Update the shadow state for one command word; return 1 when it yields a scan word.
  function automatic bit apply_command(input cmd_t w, output scan_t s);
    bit emits;
    emits = 1'b0;
    s = '0;
    case (w.action)
      ActTick: begin
        s.scan_slot  = scan_ptr;
        if (scan_ptr < DigitTotal) s.segment_byte = digit_bytes[scan_ptr];
        else s.segment_byte = led_byte;
        s.turret_lit = turret_flag;
        scan_ptr = (scan_ptr == SlotCount - 1) ? 4'd0 : scan_ptr + 4'd1;
        emits = 1'b1;
      end
      ActUpperChar: if (w.position < UpperDigits) digit_bytes[w.position] = glyph_for(w.value);
      ActLowerChar: begin
        if (w.position < LowerDigits)
          digit_bytes[UpperDigits + w.position] = glyph_for(w.value);
      end
      ActClearUpper: for (int i = 0; i < UpperDigits; i++) digit_bytes[i] = 8'h00;
      ActClearLower: for (int i = 0; i < LowerDigits; i++) digit_bytes[UpperDigits + i] = 8'h00;
      ActLed: if (w.position < LedCount) led_byte[w.position[2:0]] = w.value[0];
      ActRaw: begin
        if (w.position < DigitTotal) digit_bytes[w.position] = w.value;
        else if (w.position == DigitTotal) led_byte = w.value;
      end
      ActSetAll: begin
        for (int i = 0; i < DigitTotal; i++) digit_bytes[i] = SegAllOn;
        led_byte    = SegAllOn;
        turret_flag = 1'b1;
      end
      ActClearAll: begin
        for (int i = 0; i < DigitTotal; i++) digit_bytes[i] = 8'h00;
        led_byte    = 8'h00;
        turret_flag = 1'b0;
      end
      ActTurretOn:  turret_flag = 1'b1;
      ActTurretOff: turret_flag = 1'b0;
      default: ;
    endcase
    return emits;
  endfunction

  function automatic logic [7:0] random_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick >= 75) return 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 63);
    if (pick < 26) return ChUpperA + 8'(pick);
    if (pick < 52) return ChLowerA + 8'(pick - 26);
    if (pick < 62) return ChZero + 8'(pick - 52);
    return (pick == 62) ? ChDash : ChUnder;
  endfunction

  function automatic cmd_t random_word();
    cmd_t w;
    int   pick;
    pick       = $urandom_range(0, 99);
    w.value    = 8'($urandom_range(0, 255));
    w.position = 4'($urandom_range(0, 15));
    if (pick < 40) begin
      w.action = ActTick;
    end else if (pick < 55) begin
      w.action = ActUpperChar;
      if ($urandom_range(0, 4) != 0) w.position = 4'($urandom_range(0, UpperDigits - 1));
      w.value = random_char();
    end else if (pick < 68) begin
      w.action = ActLowerChar;
      if ($urandom_range(0, 4) != 0) w.position = 4'($urandom_range(0, LowerDigits - 1));
      w.value = random_char();
    end else if (pick < 74) begin
      w.action = ActLed;
      if ($urandom_range(0, 4) != 0) w.position = 4'($urandom_range(0, LedCount - 1));
    end else if (pick < 84) begin
      w.action = ActRaw;
      if ($urandom_range(0, 4) != 0) w.position = 4'($urandom_range(0, DigitTotal));
    end else if (pick < 86) begin
      w.action = ActClearUpper;
    end else if (pick < 88) begin
      w.action = ActClearLower;
    end else if (pick < 90) begin
      w.action = ActSetAll;
    end else if (pick < 92) begin
      w.action = ActClearAll;
    end else if (pick < 95) begin
      w.action = ActTurretOn;
    end else if (pick < 98) begin
      w.action = ActTurretOff;
    end else begin
      w.action = 4'($urandom_range(ActSpareLow, ActSpareHigh));
    end
    return w;
  endfunction

  // Entered and left at a falling edge.
  task automatic send_word(input cmd_t w, input bit typed, input scan_t typed_scan);
    scan_t predicted;
    int    gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    cmd_ch.valid    <= 1'b1;
    cmd_ch.action   <= w.action;
    cmd_ch.position <= w.position;
    cmd_ch.value    <= w.value;
    do @(posedge clk_i); while (!cmd_ch.ready);
    if (apply_command(w, predicted)) pending_scans.push_back(typed ? typed_scan : predicted);
    @(negedge clk_i);
  endtask

  // Hold the input until every expected scan word is out.
  task automatic drain_scans();
    cmd_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending_scans.size() != 0);
    burst_left = 0;
  endtask

  initial begin
    scan_ch.ready <= 1'b0;
    stall_left = 0;
    stall_mode = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(5, 40);
      end
      stall_left--;
      case (stall_mode)
        0:       scan_ch.ready <= 1'b1;
        1:       scan_ch.ready <= ($urandom_range(0, 3) != 0);
        default: scan_ch.ready <= (stall_left % 6 == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : scan_checker
    scan_t want;
    if (rst_ni && scan_ch.valid && scan_ch.ready) begin
      if (pending_scans.size() == 0) begin
        flag_mismatch($sformatf("unexpected scan word slot %0d byte %02h",
                                scan_ch.scan_slot, scan_ch.segment_byte));
      end else begin
        want = pending_scans.pop_front();
        if (scan_ch.scan_slot !== want.scan_slot)
          flag_mismatch($sformatf("scan_slot %0d, want %0d", scan_ch.scan_slot,
                                  want.scan_slot));
        if (scan_ch.segment_byte !== want.segment_byte)
          flag_mismatch($sformatf("segment_byte %02h, want %02h (slot %0d)",
                                  scan_ch.segment_byte, want.segment_byte, want.scan_slot));
        if (scan_ch.turret_lit !== want.turret_lit)
          flag_mismatch($sformatf("turret_lit %0b, want %0b", scan_ch.turret_lit,
                                  want.turret_lit));
      end
    end
  end

  initial begin
    cmd_t word;
    int   issued;
    rst_ni          = 1'b0;
    cmd_ch.valid    = 1'b0;
    cmd_ch.action   = ActTick;
    cmd_ch.position = 4'd0;
    cmd_ch.value    = 8'h00;
    mismatches      = 0;
    burst_left      = 0;
    issued          = 0;
    for (int i = 0; i < DigitTotal; i++) digit_bytes[i] = 8'h00;
    led_byte    = 8'h00;
    scan_ptr    = 4'd0;
    turret_flag = 1'b0;

    directed_rows.push_back(row_t'{cmd_t'{ActTick, 4'd0, 8'h00}, 1'b1, scan_t'{4'd0, 8'h00, 1'b0}});
    directed_rows.push_back(row_t'{cmd_t'{ActSetAll, 4'd0, 8'h00}, 1'b0, '0});
    directed_rows.push_back(row_t'{cmd_t'{ActTick, 4'd0, 8'h00}, 1'b1,
                                   scan_t'{4'd1, SegAllOn, 1'b1}});
    directed_rows.push_back(row_t'{cmd_t'{ActUpperChar, 4'd3, ChLowerZ}, 1'b0, '0});
    // out-of-range digit positions leave the store alone
    directed_rows.push_back(row_t'{cmd_t'{ActUpperChar, 4'd15, ChNine}, 1'b0, '0});
    directed_rows.push_back(row_t'{cmd_t'{ActLowerChar, 4'd0, ChDash}, 1'b0, '0});
    directed_rows.push_back(row_t'{cmd_t'{ActLowerChar, 4'd1, 8'hFF}, 1'b0, '0});
    directed_rows.push_back(row_t'{cmd_t'{ActLowerChar, 4'd2, ChUnder}, 1'b0, '0});
    directed_rows.push_back(row_t'{cmd_t'{ActLowerChar, 4'd4, ChUpperA}, 1'b0, '0});
    directed_rows.push_back(row_t'{cmd_t'{ActLed, 4'd7, 8'hFE}, 1'b0, '0});
    directed_rows.push_back(row_t'{cmd_t'{ActLed, 4'd8, 8'h00}, 1'b0, '0});
    directed_rows.push_back(row_t'{cmd_t'{ActRaw, 4'd8, 8'hA5}, 1'b0, '0});
    directed_rows.push_back(row_t'{cmd_t'{ActRaw, 4'd9, 8'h5A}, 1'b0, '0});
    directed_rows.push_back(row_t'{cmd_t'{ActRaw, 4'd2, 8'h80}, 1'b0, '0});
    for (int i = 0; i < 5; i++)
      directed_rows.push_back(row_t'{cmd_t'{ActTick, 4'd0, 8'h00}, 1'b0, '0});
    directed_rows.push_back(row_t'{cmd_t'{ActClearUpper, 4'd0, 8'h00}, 1'b0, '0});
    directed_rows.push_back(row_t'{cmd_t'{ActClearLower, 4'd0, 8'h00}, 1'b0, '0});
    directed_rows.push_back(row_t'{cmd_t'{ActTurretOff, 4'd0, 8'h00}, 1'b0, '0});
    directed_rows.push_back(row_t'{cmd_t'{ActSpareHigh, 4'd15, 8'hFF}, 1'b0, '0});
    directed_rows.push_back(row_t'{cmd_t'{ActClearAll, 4'd0, 8'h00}, 1'b0, '0});

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].typed_scan);
    drain_scans();

    while (issued < RandomWords) begin
      word = random_word();
      send_word(word, 1'b0, '0);
      if (word.action <= ActTurretOff) issued++;
      if (issued == RandomWords / 2 && word.action <= ActTurretOff) drain_scans();
    end

    cmd_ch.valid <= 1'b0;
    while (pending_scans.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ssd_pkg.sv
rtl/ssd_if.sv
rtl/ssd_frame_store.sv
rtl/seven_segment_scan_display.sv
bench/seven_segment_scan_display_test.sv
